// ===== sv/qcg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and register indexes for the quad corner geometry block.
// Depends on nothing; every other file of the block imports it.
package qcg_pkg;

  // Width of one input coordinate (two's complement).
  localparam int COORD_WIDTH = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MIN_BRICK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEFT_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RIGHT_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOP_Y     = 3'd5;

  localparam int FRAME_W = 12;
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd720;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Result field widths.
  localparam int CENT_W = 12;
  localparam int EDGE_W = 17;
  localparam int MID_W  = 12;
  localparam int SPAN_W = 17;
  localparam int PEAK_W = 16;

  // Datapath widths, all derived from the coordinate width.
  localparam int NUM_CORNERS = 4;
  localparam int NUM_COORDS  = 2 * NUM_CORNERS;
  localparam int CORNER_IDX_W = 2;
  localparam int PROD_W  = COORD_WIDTH + FRAME_W + 1;  // signed coord times height
  localparam int MAG_W   = PROD_W - 1;                 // magnitude of the product
  localparam int QIN_W   = MAG_W - 4;                  // magnitude after the divide by 16
  localparam int SCL_W   = COORD_WIDTH + 5;            // signed scaled coordinate
  localparam int SUM_W   = SCL_W + 2;                  // sum of four scaled values
  localparam int PAIR_W  = SCL_W + 1;                  // sum or difference of two

  // Divide by 240 = divide by 16 (shift), then by 15 through a reciprocal.
  // The rounding error of the reciprocal stays below one for every quotient input.
  localparam int DIV15_MUL_W = 24;
  localparam logic [DIV15_MUL_W-1:0] DIV15_MUL = 24'd8947849;
  localparam int DIV15_SHIFT = 27;
  localparam int DIV_PROD_W = QIN_W + DIV15_MUL_W;

endpackage

// ===== sv/qcg_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the quad corner geometry block: quadrilateral in,
// geometry result out, and the register write channel. Depends on qcg_pkg.

interface qcg_quad_if;
  import qcg_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] corner0_x;
  logic signed [COORD_WIDTH-1:0] corner0_y;
  logic signed [COORD_WIDTH-1:0] corner1_x;
  logic signed [COORD_WIDTH-1:0] corner1_y;
  logic signed [COORD_WIDTH-1:0] corner2_x;
  logic signed [COORD_WIDTH-1:0] corner2_y;
  logic signed [COORD_WIDTH-1:0] corner3_x;
  logic signed [COORD_WIDTH-1:0] corner3_y;

  modport source (
    output valid, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

interface qcg_result_if;
  import qcg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CENT_W-1:0]        centroid_x;
  logic [CENT_W-1:0]        centroid_y;
  logic signed [EDGE_W-1:0] left_x;
  logic signed [EDGE_W-1:0] right_x;
  logic [MID_W-1:0]         middle_x;
  logic [SPAN_W-1:0]        span;
  logic signed [EDGE_W-1:0] top_y;
  logic [PEAK_W-1:0]        peak_y;

  modport source (
    output valid, centroid_x, centroid_y, left_x, right_x, middle_x, span, top_y, peak_y,
    input  ready
  );
  modport sink (
    input  valid, centroid_x, centroid_y, left_x, right_x, middle_x, span, top_y, peak_y,
    output ready
  );
endinterface

interface qcg_cfg_if;
  import qcg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/quad_corner_geometry_top.sv =====
`timescale 1ns / 1ps
// Quad corner geometry: scales a quadrilateral to the frame and reports its centroid, x extent and top edge.
// Depends on qcg_pkg and the channel interfaces in qcg_channels.sv.

// One quadrilateral is taken per clock while the pipeline is not stalled. It passes
// five registers in order: input register, height multiply, divide by 240 (shift
// plus reciprocal multiply), corner search with centroid, and the result register.
// The only source of stalls is a full result register whose consumer is not ready;
// a stage holds only when it and every stage after it are full, so up to four more
// beats are accepted while a finished result waits.
// Register writes take effect at once and must be made while the pipeline is empty.
// The held middle x is updated as each result enters the result register, so the
// items see it strictly in order. There is no clearing pass after reset.
module quad_corner_geometry_top (
  input  logic         clk,
  input  logic         rst,
  qcg_quad_if.sink     quad,
  qcg_result_if.source result,
  qcg_cfg_if.sink      cfg
);
  import qcg_pkg::*;

  // Configuration registers.
  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic               use_minimal_brick;
  logic [FRAME_W-1:0] minimal_left_x;
  logic [FRAME_W-1:0] minimal_right_x;
  logic [FRAME_W-1:0] minimal_top_y;
  logic [MID_W-1:0]   held_middle_x;
  logic [MID_W-1:0]   held_middle_x_next;

  // Pipeline control.
  logic s0_valid, s1_valid, s2_valid, s3_valid, res_valid;
  logic s0_adv, s1_adv, s2_adv, s3_adv, res_adv;

  // Stage payloads.
  logic signed [COORD_WIDTH-1:0] s0_coord [NUM_COORDS];
  logic signed [PROD_W-1:0]      s1_prod  [NUM_COORDS];
  logic signed [SCL_W-1:0]       s2_scl   [NUM_COORDS];
  logic signed [SCL_W-1:0]       s2_scl_next [NUM_COORDS];

  logic signed [SCL_W-1:0] s3_xa, s3_xb, s3_miny, s3_miny2, s3_left_all, s3_right_all;
  logic                    s3_found_a, s3_found_b;
  logic [CENT_W-1:0]       s3_cent_x, s3_cent_y;

  logic signed [SCL_W-1:0] s3_xa_next, s3_xb_next, s3_miny_next, s3_miny2_next;
  logic signed [SCL_W-1:0] s3_left_all_next, s3_right_all_next;
  logic                    s3_found_a_next, s3_found_b_next;
  logic [CENT_W-1:0]       s3_cent_x_next, s3_cent_y_next;

  logic signed [EDGE_W-1:0] left_x_next, right_x_next, top_y_next;
  logic [SPAN_W-1:0]        span_next;
  logic [PEAK_W-1:0]        peak_y_next;

  // Effective frame size: a zero register acts as one.
  logic [FRAME_W-1:0] w_eff, h_eff, w_max, h_max;

  assign w_eff = (frame_width == '0) ? FRAME_W'(1) : frame_width;
  assign h_eff = (frame_height == '0) ? FRAME_W'(1) : frame_height;
  assign w_max = w_eff - FRAME_W'(1);
  assign h_max = h_eff - FRAME_W'(1);

  function automatic logic [CENT_W-1:0] clamp_frame(input logic signed [SUM_W-1:0] v,
                                                    input logic [FRAME_W-1:0] hi);
    logic signed [SUM_W-1:0] hi_s;
    hi_s = signed'(SUM_W'(hi));
    if (v < 0) begin
      return '0;
    end else if (v > hi_s) begin
      return CENT_W'(hi);
    end else begin
      return v[CENT_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= FRAME_WIDTH_RST;
      frame_height      <= FRAME_HEIGHT_RST;
      use_minimal_brick <= 1'b0;
      minimal_left_x    <= '0;
      minimal_right_x   <= '0;
      minimal_top_y     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:   frame_width       <= cfg.data;
        REG_FRAME_HEIGHT:  frame_height      <= cfg.data;
        REG_USE_MIN_BRICK: use_minimal_brick <= cfg.data[0];
        REG_MIN_LEFT_X:    minimal_left_x    <= cfg.data;
        REG_MIN_RIGHT_X:   minimal_right_x   <= cfg.data;
        REG_MIN_TOP_Y:     minimal_top_y     <= cfg.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- stage handshake
  assign res_adv = !res_valid || result.ready;
  assign s3_adv  = !s3_valid || res_adv;
  assign s2_adv  = !s2_valid || s3_adv;
  assign s1_adv  = !s1_valid || s2_adv;
  assign s0_adv  = !s0_valid || s1_adv;
  assign quad.ready = s0_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s0_adv) begin
        s0_valid <= quad.valid;
      end
      if (s1_adv) begin
        s1_valid <= s0_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (s3_adv) begin
        s3_valid <= s2_valid;
      end
      if (res_adv) begin
        res_valid <= s3_valid;
      end
    end
  end
  assign result.valid = res_valid;

  // ------------------------------------------- stage 0: input register
  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s0_coord[0] <= quad.corner0_x;
      s0_coord[1] <= quad.corner0_y;
      s0_coord[2] <= quad.corner1_x;
      s0_coord[3] <= quad.corner1_y;
      s0_coord[4] <= quad.corner2_x;
      s0_coord[5] <= quad.corner2_y;
      s0_coord[6] <= quad.corner3_x;
      s0_coord[7] <= quad.corner3_y;
    end
  end

  // ------------------------------------- stage 1: multiply by frame height
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int j = 0; j < NUM_COORDS; j++) begin
        s1_prod[j] <= PROD_W'(s0_coord[j]) * signed'(PROD_W'(h_eff));
      end
    end
  end

  // ------------------------ stage 2: divide by 240, truncating toward zero
  always_comb begin
    logic [PROD_W-1:0]     mag_full;
    logic [QIN_W-1:0]      quot_in;
    logic [DIV_PROD_W-1:0] recip_prod;
    logic [SCL_W-1:0]      quot;
    for (int j = 0; j < NUM_COORDS; j++) begin
      mag_full   = s1_prod[j][PROD_W-1] ? PROD_W'(-s1_prod[j]) : PROD_W'(s1_prod[j]);
      quot_in    = mag_full[MAG_W-1:4];
      recip_prod = DIV_PROD_W'(quot_in) * DIV_PROD_W'(DIV15_MUL);
      quot       = SCL_W'(recip_prod[DIV_PROD_W-1:DIV15_SHIFT]);
      s2_scl_next[j] = s1_prod[j][PROD_W-1] ? signed'(-quot) : signed'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_scl <= s2_scl_next;
    end
  end

  // -------------------- stage 3: topmost corners, centroid and x extremes
  always_comb begin
    logic signed [SUM_W-1:0]  sum_x, sum_y, avg_x, avg_y;
    logic signed [SCL_W-1:0]  miny, miny2, lft, rgt;
    logic [CORNER_IDX_W-1:0]  idx_a, idx_b;
    logic                     fa, fb;
    sum_x = '0;
    sum_y = '0;
    lft   = signed'(SCL_W'(w_eff));
    rgt   = '0;
    miny  = signed'(SCL_W'(h_eff));
    miny2 = signed'(SCL_W'(h_eff));
    idx_a = '0;
    idx_b = '0;
    fa    = 1'b0;
    fb    = 1'b0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      sum_x = sum_x + SUM_W'(s2_scl[2*i]);
      sum_y = sum_y + SUM_W'(s2_scl[2*i+1]);
      if (s2_scl[2*i] < lft) begin
        lft = s2_scl[2*i];
      end
      if (s2_scl[2*i] > rgt) begin
        rgt = s2_scl[2*i];
      end
      // Strict compare: ties keep the lower corner number.
      if (s2_scl[2*i+1] < miny) begin
        miny  = s2_scl[2*i+1];
        idx_a = CORNER_IDX_W'(i);
        fa    = 1'b1;
      end
    end
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if (!(fa && idx_a == CORNER_IDX_W'(i)) && s2_scl[2*i+1] < miny2) begin
        miny2 = s2_scl[2*i+1];
        idx_b = CORNER_IDX_W'(i);
        fb    = 1'b1;
      end
    end
    // Quarter of the sum, truncated toward zero.
    avg_x = (sum_x + (sum_x[SUM_W-1] ? SUM_W'(3) : SUM_W'(0))) >>> 2;
    avg_y = (sum_y + (sum_y[SUM_W-1] ? SUM_W'(3) : SUM_W'(0))) >>> 2;

    s3_cent_x_next    = clamp_frame(avg_x, w_max);
    s3_cent_y_next    = clamp_frame(avg_y, h_max);
    s3_xa_next        = s2_scl[{idx_a, 1'b0}];
    s3_xb_next        = s2_scl[{idx_b, 1'b0}];
    s3_miny_next      = miny;
    s3_miny2_next     = miny2;
    s3_left_all_next  = lft;
    s3_right_all_next = rgt;
    s3_found_a_next   = fa;
    s3_found_b_next   = fa && fb;
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_cent_x    <= s3_cent_x_next;
      s3_cent_y    <= s3_cent_y_next;
      s3_xa        <= s3_xa_next;
      s3_xb        <= s3_xb_next;
      s3_miny      <= s3_miny_next;
      s3_miny2     <= s3_miny2_next;
      s3_left_all  <= s3_left_all_next;
      s3_right_all <= s3_right_all_next;
      s3_found_a   <= s3_found_a_next;
      s3_found_b   <= s3_found_b_next;
    end
  end

  // ------------------ stage 4: top edge, middle x and minimal brick override
  always_comb begin
    logic signed [SCL_W-1:0]  xb_eff;
    logic signed [PAIR_W-1:0] pair_sum, pair_diff, mid_raw;
    logic [FRAME_W:0]         brick_sum;
    logic [MID_W-1:0]         mid_clamped;
    xb_eff    = s3_found_b ? s3_xb : s3_xa;
    pair_sum  = PAIR_W'(s3_xa) + PAIR_W'(xb_eff);
    pair_diff = PAIR_W'(s3_xa) - PAIR_W'(xb_eff);
    brick_sum = (FRAME_W+1)'(minimal_left_x) + (FRAME_W+1)'(minimal_right_x);
    if (s3_found_b) begin
      mid_raw = (pair_sum + (pair_sum[PAIR_W-1] ? PAIR_W'(1) : PAIR_W'(0))) >>> 1;
    end else begin
      mid_raw = signed'(PAIR_W'(held_middle_x));
    end
    mid_clamped = clamp_frame(SUM_W'(mid_raw), w_max);

    held_middle_x_next = held_middle_x;
    left_x_next  = EDGE_W'(s3_left_all);
    right_x_next = EDGE_W'(s3_right_all);
    span_next    = '0;
    top_y_next   = '0;
    peak_y_next  = s3_miny[SCL_W-1] ? '0 : PEAK_W'(s3_miny);

    if (s3_found_a) begin
      held_middle_x_next = mid_clamped;
      if (s3_xa < xb_eff) begin
        left_x_next  = EDGE_W'(s3_xa);
        right_x_next = EDGE_W'(xb_eff);
      end else begin
        left_x_next  = EDGE_W'(xb_eff);
        right_x_next = EDGE_W'(s3_xa);
      end
      if (s3_found_b) begin
        span_next  = pair_diff[PAIR_W-1] ? SPAN_W'(-pair_diff) : SPAN_W'(pair_diff);
        top_y_next = EDGE_W'(s3_miny2);
      end
    end

    if (use_minimal_brick) begin
      held_middle_x_next = brick_sum[FRAME_W:1];
      top_y_next         = EDGE_W'(minimal_top_y);
      peak_y_next        = PEAK_W'(minimal_top_y);
      span_next          = (minimal_right_x >= minimal_left_x) ?
                           SPAN_W'(minimal_right_x - minimal_left_x) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_middle_x <= '0;
    end else if (res_adv && s3_valid) begin
      held_middle_x <= held_middle_x_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv) begin
      result.centroid_x <= s3_cent_x;
      result.centroid_y <= s3_cent_y;
      result.left_x     <= left_x_next;
      result.right_x    <= right_x_next;
      result.middle_x   <= held_middle_x_next;
      result.span       <= span_next;
      result.top_y      <= top_y_next;
      result.peak_y     <= peak_y_next;
    end
  end

`ifndef SYNTHESIS
  // A result waiting on the consumer is never overwritten or dropped.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> res_valid)
    else $error("result register lost a waiting beat");

  // The held middle x moves only when a result enters the result register.
  a_held_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !(res_adv && s3_valid) |=> $stable(held_middle_x))
    else $error("held middle x changed without a result");

  // Outside brick mode the span is the distance between the two top corners or zero.
  a_span_matches_edges: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !use_minimal_brick) |->
      (result.span == 0) || (result.span == SPAN_W'(result.right_x - result.left_x)))
    else $error("span disagrees with left and right x");

  // The middle x reported is the value held for the next item.
  a_middle_is_held: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (result.middle_x == held_middle_x))
    else $error("middle x differs from held value");
`endif

endmodule

// ===== dv/qcg_geometry_monitor.sv =====
`timescale 1ns / 1ps
// Monitor for the quad corner geometry block. It watches the quadrilateral,
// result and register channels, predicts each result and compares it field by field.
// Depends on qcg_pkg and the channel interfaces in qcg_channels.sv.
module qcg_geometry_monitor (
  input  logic   clk,
  input  logic   rst,
  qcg_quad_if    quad,
  qcg_result_if  result,
  qcg_cfg_if     cfg,
  output int     fail_count,
  output int     pending
);
  import qcg_pkg::*;

  // Corners arrive on a 320x240 grid; every coordinate is scaled by height/240.
  localparam int GRID_HEIGHT = 240;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [CENT_W-1:0]        centroid_x;
    logic [CENT_W-1:0]        centroid_y;
    logic signed [EDGE_W-1:0] left_x;
    logic signed [EDGE_W-1:0] right_x;
    logic [MID_W-1:0]         middle_x;
    logic [SPAN_W-1:0]        span;
    logic signed [EDGE_W-1:0] top_y;
    logic [PEAK_W-1:0]        peak_y;
  } geom_t;

  logic [FRAME_W-1:0]    frame_w;
  logic [FRAME_W-1:0]    frame_h;
  logic                  use_brick;
  logic [CFG_DATA_W-1:0] brick_left;
  logic [CFG_DATA_W-1:0] brick_right;
  logic [CFG_DATA_W-1:0] brick_top;
  logic [MID_W-1:0]      held_mid;

  geom_t geom_q[$];
  int    result_seq = 0;
  int    mismatches = 0;

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Works out one result and advances the held middle x, in acceptance order.
  function automatic geom_t predict_geometry(
    input logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] raw
  );
    geom_t g;
    int w, h, c, sum_x, sum_y, lo_x, hi_x, low_y, low_y2;
    int mid, span_v, top_v, peak_v, top_i, next_i;
    int x [NUM_CORNERS];
    int y [NUM_CORNERS];
    w = (frame_w == 0) ? 1 : int'(frame_w);
    h = (frame_h == 0) ? 1 : int'(frame_h);
    sum_x = 0;
    sum_y = 0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      c = int'($signed(raw[2*i]));
      x[i] = c * h / GRID_HEIGHT;
      c = int'($signed(raw[2*i+1]));
      y[i] = c * h / GRID_HEIGHT;
      sum_x += x[i];
      sum_y += y[i];
    end

    // A corner only counts as topmost when it lies strictly above the frame bottom.
    lo_x = w;
    hi_x = 0;
    low_y = h;
    top_i = -1;
    next_i = -1;
    span_v = 0;
    top_v = 0;
    mid = int'(held_mid);
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if (x[i] < lo_x) lo_x = x[i];
      if (x[i] > hi_x) hi_x = x[i];
      if (y[i] < low_y) begin
        low_y = y[i];
        top_i = i;
      end
    end
    peak_v = (low_y < 0) ? 0 : low_y;

    if (top_i >= 0) begin
      low_y2 = h;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        if (i != top_i && y[i] < low_y2) begin
          low_y2 = y[i];
          next_i = i;
        end
      end
      if (next_i >= 0) begin
        mid = (x[top_i] + x[next_i]) / 2;
        span_v = x[top_i] - x[next_i];
        if (span_v < 0) span_v = -span_v;
        top_v = low_y2;
      end else begin
        next_i = top_i;
      end
      // Without a second corner the held value is kept but still clamped.
      mid = clamp_to(mid, w - 1);
      held_mid = MID_W'(mid);
      if (x[top_i] < x[next_i]) begin
        lo_x = x[top_i];
        hi_x = x[next_i];
      end else begin
        lo_x = x[next_i];
        hi_x = x[top_i];
      end
    end

    if (use_brick) begin
      mid = (int'(brick_left) + int'(brick_right)) / 2;
      held_mid = MID_W'(mid);
      top_v = int'(brick_top);
      peak_v = top_v;
      span_v = int'(brick_right) - int'(brick_left);
      if (span_v < 0) span_v = 0;
    end

    g.centroid_x = CENT_W'(clamp_to(sum_x / NUM_CORNERS, w - 1));
    g.centroid_y = CENT_W'(clamp_to(sum_y / NUM_CORNERS, h - 1));
    g.left_x     = EDGE_W'(lo_x);
    g.right_x    = EDGE_W'(hi_x);
    g.middle_x   = held_mid;
    g.span       = SPAN_W'(span_v);
    g.top_y      = EDGE_W'(top_v);
    g.peak_y     = PEAK_W'(peak_v);
    return g;
  endfunction

  task automatic apply_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    case (index)
      REG_FRAME_WIDTH:   frame_w = value;
      REG_FRAME_HEIGHT:  frame_h = value;
      REG_USE_MIN_BRICK: use_brick = value[0];
      REG_MIN_LEFT_X:    brick_left = value;
      REG_MIN_RIGHT_X:   brick_right = value;
      REG_MIN_TOP_Y:     brick_top = value;
      default: ;
    endcase
  endtask

  // Printing stops after the first PRINT_LIMIT mismatches so a broken block cannot flood the log.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [SPAN_W-1:0] seen,
                               input logic [SPAN_W-1:0] want);
    if (seen !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_seq, name, seen, want));
  endtask

  always @(posedge clk) begin
    geom_t seen, want;
    if (rst) begin
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      use_brick = 1'b0;
      brick_left = '0;
      brick_right = '0;
      brick_top = '0;
      held_mid = '0;
      geom_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) apply_register(cfg.index, cfg.data);

      // Compare before queuing so a same-cycle input beat never matches itself.
      if (result.valid && result.ready) begin
        seen.centroid_x = result.centroid_x;
        seen.centroid_y = result.centroid_y;
        seen.left_x     = result.left_x;
        seen.right_x    = result.right_x;
        seen.middle_x   = result.middle_x;
        seen.span       = result.span;
        seen.top_y      = result.top_y;
        seen.peak_y     = result.peak_y;
        if (geom_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no quadrilateral outstanding",
                                    result_seq));
        end else begin
          want = geom_q.pop_front();
          compare_field("centroid_x", SPAN_W'(seen.centroid_x), SPAN_W'(want.centroid_x));
          compare_field("centroid_y", SPAN_W'(seen.centroid_y), SPAN_W'(want.centroid_y));
          compare_field("left_x", seen.left_x, want.left_x);
          compare_field("right_x", seen.right_x, want.right_x);
          compare_field("middle_x", SPAN_W'(seen.middle_x), SPAN_W'(want.middle_x));
          compare_field("span", seen.span, want.span);
          compare_field("top_y", seen.top_y, want.top_y);
          compare_field("peak_y", SPAN_W'(seen.peak_y), SPAN_W'(want.peak_y));
        end
        result_seq++;
      end

      if (quad.valid && quad.ready)
        geom_q.insert(geom_q.size(),
                      predict_geometry({quad.corner3_y, quad.corner3_x,
                                        quad.corner2_y, quad.corner2_x,
                                        quad.corner1_y, quad.corner1_x,
                                        quad.corner0_y, quad.corner0_x}));
    end
    pending <= geom_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for quad_corner_geometry_top: clock, reset, register setup and
// quadrilateral stimulus under several pacing phases, plus the final verdict.
// Depends on qcg_pkg, qcg_channels.sv and qcg_geometry_monitor.
module tb_top;
  import qcg_pkg::*;

  typedef enum int {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH, PACE_HOLD} pace_t;

  localparam int RESET_CYCLES    = 11;
  localparam int HOLD_CYCLES     = 200;
  localparam int PHASES          = 12;
  localparam int QUADS_PER_PHASE = 75;
  localparam int DRAIN_EVERY     = 30;
  localparam int SETTLE_CYCLES   = 20;
  localparam int BUSY_PCT        = 66;
  localparam int LIGHT_PCT       = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic  clk = 1'b0;
  logic  rst;
  pace_t pace = PACE_FREE;
  int    src_idle_pct = 0;
  int    hold_count = 0;
  int    fail_count;
  int    pending;

  qcg_quad_if   quad ();
  qcg_result_if result ();
  qcg_cfg_if    cfg ();

  quad_corner_geometry_top uut (
    .clk(clk), .rst(rst), .quad(quad), .result(result), .cfg(cfg)
  );

  qcg_geometry_monitor geometry_mon (
    .clk(clk), .rst(rst), .quad(quad), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // Result side: random stalls per phase, and in the hold phase a long stretch
  // with ready low so the pipeline fills and pushes back on the input.
  always @(posedge clk) begin
    if (pace == PACE_HOLD && hold_count < HOLD_CYCLES) begin
      result.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (pace != PACE_HOLD) hold_count <= 0;
      case (pace)
        PACE_SNK:  result.ready <= ($urandom_range(0, 99) >= BUSY_PCT);
        PACE_BOTH: result.ready <= ($urandom_range(0, 99) >= LIGHT_PCT);
        default:   result.ready <= 1'b1;
      endcase
    end
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic set_pace(input pace_t p);
    pace <= p;
    src_idle_pct = (p == PACE_SRC) ? BUSY_PCT : (p == PACE_BOTH) ? LIGHT_PCT : 0;
  endtask

  task automatic send_quad(input int x0, y0, x1, y1, x2, y2, x3, y3);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      quad.valid <= 1'b0;
      @(posedge clk);
    end
    quad.valid <= 1'b1;
    quad.corner0_x <= COORD_WIDTH'(x0);
    quad.corner0_y <= COORD_WIDTH'(y0);
    quad.corner1_x <= COORD_WIDTH'(x1);
    quad.corner1_y <= COORD_WIDTH'(y1);
    quad.corner2_x <= COORD_WIDTH'(x2);
    quad.corner2_y <= COORD_WIDTH'(y2);
    quad.corner3_x <= COORD_WIDTH'(x3);
    quad.corner3_y <= COORD_WIDTH'(y3);
    do @(posedge clk); while (!quad.ready);
  endtask

  task automatic wait_drained();
    quad.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Leaves valid high so register beats can follow back to back.
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic write_settings(input int w, h, brick, lx, rx, ty);
    wait_drained();
    cfg_beat(REG_FRAME_WIDTH, w);
    cfg_beat(REG_FRAME_HEIGHT, h);
    cfg_beat(REG_USE_MIN_BRICK, brick);
    cfg_beat(REG_MIN_LEFT_X, lx);
    cfg_beat(REG_MIN_RIGHT_X, rx);
    cfg_beat(REG_MIN_TOP_Y, ty);
    cfg.valid <= 1'b0;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0: return -2048;
      1: return 2047;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly shapes on the reference grid, with ties and corners near the frame
  // bottom, plus fully random and extreme coordinates.
  task automatic random_quad();
    int v [NUM_COORDS];
    int style, base;
    style = $urandom_range(0, 99);
    base = int'($urandom_range(0, 290)) - 30;
    for (int k = 0; k < NUM_COORDS; k++) begin
      if (style < 25) v[k] = int'($urandom_range(0, 4095));
      else if (style >= 90) v[k] = pick_extreme();
      else if (k % 2 == 0) v[k] = int'($urandom_range(0, 400)) - 40;
      else if (style < 65) v[k] = int'($urandom_range(0, 310)) - 30;
      else if (style < 80) v[k] = base + int'($urandom_range(0, 1));
      else v[k] = int'($urandom_range(234, 246));
    end
    send_quad(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  initial begin
    rst <= 1'b1;
    quad.valid <= 1'b0;
    quad.corner0_x <= '0;
    quad.corner0_y <= '0;
    quad.corner1_x <= '0;
    quad.corner1_y <= '0;
    quad.corner2_x <= '0;
    quad.corner2_y <= '0;
    quad.corner3_x <= '0;
    quad.corner3_y <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    set_pace(PACE_FREE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed shapes under the reset frame of 720x480.
    send_quad(0, 0, 0, 0, 0, 0, 0, 0);
    send_quad(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048);
    // Nothing above the frame bottom: no topmost corner at all.
    send_quad(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
    send_quad(2047, 0, -2048, 0, 2047, 100, -2048, 100);
    // Only one corner above the bottom, so it stands in for the second one.
    send_quad(50, 300, 120, 100, 200, 300, 10, 300);
    send_quad(10, 240, 20, 239, 30, 240, 40, 241);
    send_quad(10, 240, 20, 240, 30, 240, 40, 240);
    send_quad(5, 10, 15, 10, 25, 10, 35, 10);
    send_quad(0, -5, 40, -3, 40, 50, 0, 60);
    send_quad(10, 20, 310, 20, 310, 220, 10, 220);
    send_quad(400, 0, 400, 1, 400, 200, 400, 200);
    send_quad(-100, 0, -50, 1, 0, 200, 0, 200);
    send_quad(2730, 1365, 1365, 2730, 2730, 1365, 1365, 2730);
    send_quad(300, 5, 20, 8, 150, 200, 160, 210);

    // Writes past the register list must leave the settings alone.
    wait_drained();
    cfg_beat(REG_SPARE_6, 4095);
    cfg_beat(REG_SPARE_7, 2748);
    cfg.valid <= 1'b0;
    send_quad(100, 50, 200, 60, 200, 150, 100, 150);
    send_quad(2047, -2048, -2048, 2047, 0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: write_settings(4095, 4095, 0, 0, 0, 0);
        2: write_settings(1, 1, 0, 4095, 4095, 4095);
        3: write_settings(0, 0, 0, 0, 0, 0);
        4: write_settings(320, 240, 1, 100, 220, 37);
        5: write_settings(640, 480, 1, 3000, 12, 4095);
        6: write_settings(4095, 480, 1, 4095, 4095, 4095);
        7: write_settings(720, 480, 0, 0, 0, 0);
        default: write_settings($urandom_range(1, 4095), $urandom_range(1, 4095),
                                int'($urandom_range(0, 3) == 0), $urandom_range(0, 4095),
                                $urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
      set_pace(pace_t'(p % 5));
      for (int n = 0; n < QUADS_PER_PHASE; n++) begin
        if (n > 0 && n % DRAIN_EVERY == 0) wait_drained();
        random_quad();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/qcg_pkg.sv
sv/qcg_channels.sv
sv/quad_corner_geometry_top.sv
dv/qcg_geometry_monitor.sv
dv/tb_top.sv
